// File: design/tdfe_pkg.sv
package tdfe_pkg;

	localparam int VALUE_BITS = 16;
	localparam int FIELD_BITS = 16;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [FIELD_BITS-1:0] field_t;

	// parse phase codes
	localparam logic [2:0] PH_SEEK_TITLE = 3'd0;
	localparam logic [2:0] PH_SKIP_TITLE = 3'd1;
	localparam logic [2:0] PH_SEEK_BOLD  = 3'd2;
	localparam logic [2:0] PH_LETTER     = 3'd3;
	localparam logic [2:0] PH_VALUE      = 3'd4;
	localparam logic [2:0] PH_ERROR      = 3'd5;

	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_X    = 2'd1;
	localparam logic [1:0] TGT_Y    = 2'd2;
	localparam logic [1:0] TGT_C    = 2'd3;

	localparam logic [1:0] OC_OK         = 2'd0;
	localparam logic [1:0] OC_ERROR      = 2'd1;
	localparam logic [1:0] OC_INCOMPLETE = 2'd2;

	localparam logic [2:0] TITLE_LEN = 3'd7;
	localparam logic [2:0] BOLD_LEN  = 3'd3;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_Y     = 8'h59;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [2:0] phase;
		logic [2:0] match_count;
		logic [1:0] target;
	} parse_state_t;

	// "<title>"
	function automatic logic [7:0] title_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = 8'h3C;
			3'd1: ch = 8'h74;
			3'd2: ch = 8'h69;
			3'd3: ch = 8'h74;
			3'd4: ch = 8'h6C;
			3'd5: ch = 8'h65;
			3'd6: ch = 8'h3E;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// "<b>"
	function automatic logic [7:0] bold_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = 8'h3C;
			3'd1: ch = 8'h62;
			3'd2: ch = 8'h3E;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// File: design/tdfe_in_if.sv
interface tdfe_in_if;
	import tdfe_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

// File: design/tdfe_out_if.sv
interface tdfe_out_if;
	import tdfe_pkg::*;

	logic       valid;
	logic       ready;
	field_t     x_position;
	logic [FIELD_BITS-1:0] y_position;
	logic [FIELD_BITS-1:0] click_code;
	logic [1:0] outcome;
	logic       value_clipped;

	modport source(output valid, output x_position, output y_position, output click_code,
		output outcome, output value_clipped, input ready);
	modport sink(input valid, input x_position, input y_position, input click_code,
		input outcome, input value_clipped, output ready);
endinterface

// File: design/tdfe_parse.sv
module tdfe_parse (
	input  tdfe_pkg::parse_state_t cur,
	input  logic [7:0]             ch,
	output tdfe_pkg::parse_state_t nxt,
	output logic                   digit_en,
	output logic [3:0]             digit
);
	import tdfe_pkg::*;

	logic is_digit;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign digit    = ch[3:0];

	always_comb begin
		nxt      = cur;
		digit_en = 1'b0;
		unique case (cur.phase)
			PH_SEEK_TITLE: begin
				if (cur.match_count < TITLE_LEN && ch == title_char(cur.match_count)) begin
					if (cur.match_count + 3'd1 == TITLE_LEN) begin
						nxt.phase       = PH_SKIP_TITLE;
						nxt.match_count = 3'd0;
					end else begin
						nxt.match_count = cur.match_count + 3'd1;
					end
				end else begin
					// a mismatching byte is not retried as the tag's first character
					nxt.match_count = 3'd0;
				end
			end
			PH_SKIP_TITLE: begin
				if (ch == CH_LT) begin
					nxt.phase       = PH_SEEK_BOLD;
					nxt.match_count = 3'd0;
				end
			end
			PH_SEEK_BOLD: begin
				if (cur.match_count < BOLD_LEN && ch == bold_char(cur.match_count)) begin
					if (cur.match_count + 3'd1 == BOLD_LEN) begin
						nxt.phase       = PH_LETTER;
						nxt.match_count = 3'd0;
					end else begin
						nxt.match_count = cur.match_count + 3'd1;
					end
				end else begin
					nxt.match_count = 3'd0;
				end
			end
			PH_LETTER: begin
				nxt.match_count = 3'd0;
				priority if (ch == CH_X) begin
					nxt.target = TGT_X;
					nxt.phase  = PH_VALUE;
				end else if (ch == CH_Y) begin
					nxt.target = TGT_Y;
					nxt.phase  = PH_VALUE;
				end else if (ch == CH_C) begin
					nxt.target = TGT_C;
					nxt.phase  = PH_VALUE;
				end else begin
					nxt.phase = PH_ERROR;
				end
			end
			PH_VALUE: begin
				priority if (ch == CH_LT) begin
					nxt.phase       = PH_SEEK_BOLD;
					nxt.match_count = 3'd0;
				end else if (is_digit) begin
					digit_en = (cur.target != TGT_NONE);
				end else if (ch != CH_COLON && ch != CH_SPACE) begin
					nxt.phase       = PH_ERROR;
					nxt.match_count = 3'd0;
				end
			end
			default: begin
				// error phase and unused codes hold
			end
		endcase
	end
endmodule

// File: design/tdfe_accum.sv
module tdfe_accum (
	input  tdfe_pkg::value_t acc,
	input  logic [3:0]       digit,
	output tdfe_pkg::value_t sum,
	output logic             clipped
);
	import tdfe_pkg::*;

	localparam int WIDE_BITS = VALUE_BITS + 4;

	logic [WIDE_BITS-1:0] ext;
	logic [WIDE_BITS-1:0] wide;

	// acc * 10 + digit, as shift-and-add
	assign ext     = WIDE_BITS'(acc);
	assign wide    = (ext << 3) + (ext << 1) + WIDE_BITS'(digit);
	assign clipped = |wide[WIDE_BITS-1:VALUE_BITS];
	assign sum     = clipped ? '1 : wide[VALUE_BITS-1:0];
endmodule

// File: design/tagged_decimal_field_extractor_core.sv
// Parses a markup document arriving one byte per transfer on byte_stream
// (data_byte, last_byte). After "<title>" and the title text, each "<b>"
// tag is followed by X, Y or C and a decimal value that is accumulated,
// saturating at 65535. For the transfer that carries last_byte, one result
// goes out on result: the three values, the outcome (0 ok, 1 parse error,
// 2 detail incomplete) and the clip flag. An ok outcome clears the values
// and restarts the title search; other outcomes keep all state.
// Throughput: one byte per clock while no last byte waits for the output
// register. Each byte is captured in an input register and processed from
// there by the phase/tag logic and one shift-and-add digit accumulator; a
// result is loaded into the output register when its last byte advances
// out of the input register.
// Reset (arst_n low) empties both registers and returns the parser to the
// title search with all values zero.
// When the receiver stalls, bytes without last_byte keep flowing; a last
// byte waits in the input register until the output register frees up,
// and the input then stops accepting.
module tagged_decimal_field_extractor_core (
	input  logic       clk,
	input  logic       arst_n,
	tdfe_in_if.sink    byte_stream,
	tdfe_out_if.source result
);
	import tdfe_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         adv_s1;

	parse_state_t state_q;
	parse_state_t state_nxt;
	value_t       x_q;
	value_t       y_q;
	value_t       c_q;
	logic         clip_q;

	logic         digit_en;
	logic [3:0]   digit;
	value_t       acc_sel;
	value_t       acc_sum;
	logic         acc_clip;
	value_t       x_nxt;
	value_t       y_nxt;
	value_t       c_nxt;
	logic         clip_nxt;
	logic [1:0]   oc_nxt;

	logic         valid_s2;
	field_t       x_s2;
	field_t       y_s2;
	field_t       c_s2;
	logic [1:0]   oc_s2;
	logic         clip_s2;

	tdfe_parse u_parse (
		.cur      (state_q),
		.ch       (byte_s1),
		.nxt      (state_nxt),
		.digit_en (digit_en),
		.digit    (digit)
	);

	always_comb begin
		unique case (state_q.target)
			TGT_X:   acc_sel = x_q;
			TGT_Y:   acc_sel = y_q;
			default: acc_sel = c_q;
		endcase
	end

	tdfe_accum u_accum (
		.acc     (acc_sel),
		.digit   (digit),
		.sum     (acc_sum),
		.clipped (acc_clip)
	);

	always_comb begin
		x_nxt    = x_q;
		y_nxt    = y_q;
		c_nxt    = c_q;
		clip_nxt = clip_q;
		if (digit_en) begin
			clip_nxt = clip_q | acc_clip;
			unique case (state_q.target)
				TGT_X:   x_nxt = acc_sum;
				TGT_Y:   y_nxt = acc_sum;
				default: c_nxt = acc_sum;
			endcase
		end
	end

	always_comb begin
		unique case (state_nxt.phase)
			PH_SEEK_BOLD:  oc_nxt = OC_OK;
			PH_SEEK_TITLE,
			PH_SKIP_TITLE,
			PH_LETTER,
			PH_VALUE:      oc_nxt = OC_INCOMPLETE;
			default:       oc_nxt = OC_ERROR;
		endcase
	end

	// a last byte advances only when the output register can take its result
	assign adv_s1            = valid_s1 && (!last_s1 || !valid_s2 || result.ready);
	assign byte_stream.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			byte_s1 <= byte_stream.data_byte;
			last_s1 <= byte_stream.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_SEEK_TITLE, match_count: 3'd0, target: TGT_NONE};
			x_q     <= '0;
			y_q     <= '0;
			c_q     <= '0;
			clip_q  <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1 && oc_nxt == OC_OK) begin
				state_q <= '{phase: PH_SEEK_TITLE, match_count: 3'd0, target: TGT_NONE};
				x_q     <= '0;
				y_q     <= '0;
				c_q     <= '0;
				clip_q  <= 1'b0;
			end else begin
				state_q <= state_nxt;
				x_q     <= x_nxt;
				y_q     <= y_nxt;
				c_q     <= c_nxt;
				clip_q  <= clip_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			x_s2    <= FIELD_BITS'(x_nxt);
			y_s2    <= FIELD_BITS'(y_nxt);
			c_s2    <= FIELD_BITS'(c_nxt);
			oc_s2   <= oc_nxt;
			clip_s2 <= clip_nxt;
		end
	end

	assign result.valid         = valid_s2;
	assign result.x_position    = x_s2;
	assign result.y_position    = y_s2;
	assign result.click_code    = c_s2;
	assign result.outcome       = oc_s2;
	assign result.value_clipped = clip_s2;
endmodule
